[rtl/b64fb_pkg.sv]
// ----------------------------------------------------------------------------
// b64fb_pkg
// Shared types, constants and base64 helpers for the framebuffer pixel writer.
// ----------------------------------------------------------------------------
package b64fb_pkg;

	localparam int MAX_WIDTH    = 64;
	localparam int MAX_HEIGHT   = 64;
	localparam int HEADER_CHARS = 72;
	localparam int PIX_GROUPS   = (MAX_WIDTH * MAX_HEIGHT + 2) / 3;
	localparam int STORE_CHARS  = HEADER_CHARS + PIX_GROUPS * 8;

	// Field widths fixed by the interface.
	localparam int ADDR_W = 14;
	localparam int DIM_W  = 7;
	localparam int POS_W  = 6;

	// A pixel index is at most 63 * 127 + 63, which fits in 13 bits.
	localparam int PIX_W   = 13;
	localparam int GROUP_W = 12;
	localparam int MUL_B_W = 12;
	localparam int MUL_W   = PIX_W + MUL_B_W;

	// Division by three: floor(pix * 2731 / 8192) is exact for every 13-bit pix.
	localparam logic [MUL_B_W-1:0] RECIP_3     = 12'd2731;
	localparam int                 RECIP_SHIFT = 13;

	localparam logic [7:0] CHAR_FILL = 8'h41;  // 'A'

	// Request kinds.
	localparam logic [1:0] KIND_DRAW  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Position of a pixel inside its three-pixel group.
	localparam logic [1:0] PHASE_FIRST = 2'd0;
	localparam logic [1:0] PHASE_MID   = 2'd1;
	localparam logic [1:0] PHASE_LAST  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MUL_DIV,
		ST_SPLIT,
		ST_RD_A,
		ST_RD_B,
		ST_WRITE,
		ST_RD_WAIT,
		ST_FINISH
	} state_t;

	// Characters to store for one draw: chars[i] goes to base + first_off + i.
	typedef struct packed {
		logic [2:0]      first_off;
		logic [1:0]      last_cnt;
		logic [3:0][7:0] chars;
	} draw_plan_t;

	function automatic logic [7:0] b64_char(input logic [5:0] six);
		logic [7:0] v;
		v = {2'b00, six};
		if (six < 6'd26)      return 8'h41 + v;
		else if (six < 6'd52) return 8'h61 + v - 8'd26;
		else if (six < 6'd62) return 8'h30 + v - 8'd52;
		else if (six == 6'd62) return 8'h2B;
		else                  return 8'h2F;
	endfunction

	// Decoded value of a stored character: '=' gives 64, anything unknown 255.
	function automatic logic [7:0] b64_value(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A)      return c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7A) return c - 8'h61 + 8'd26;
		else if (c >= 8'h30 && c <= 8'h39) return c - 8'h30 + 8'd52;
		else if (c == 8'h2B)               return 8'd62;
		else if (c == 8'h2F)               return 8'd63;
		else if (c == 8'h3D)               return 8'd64;
		else                               return 8'd255;
	endfunction

endpackage

[rtl/b64fb_codec.sv]
// ----------------------------------------------------------------------------
// b64fb_codec
// Builds the characters that one pixel draw writes into its group.
// ----------------------------------------------------------------------------
module b64fb_codec
	import b64fb_pkg::*;
(
	input  logic [1:0]  phase,
	input  logic [15:0] color,
	input  logic [7:0]  keep_a,  // stored character at group offset 2
	input  logic [7:0]  keep_b,  // stored character at group offset 5
	output draw_plan_t  plan
);

	logic [7:0] lo;
	logic [7:0] hi;
	logic [7:0] ka;
	logic [7:0] kb;

	assign lo = color[7:0];
	assign hi = color[15:8];
	assign ka = b64_value(keep_a);
	assign kb = b64_value(keep_b);

	always_comb begin
		plan.first_off = 3'd0;
		plan.last_cnt  = 2'd2;
		plan.chars     = '0;
		case (phase)
			PHASE_FIRST: begin
				plan.first_off = 3'd0;
				plan.last_cnt  = 2'd2;
				plan.chars[0]  = b64_char(lo[7:2]);
				plan.chars[1]  = b64_char({lo[1:0], hi[7:4]});
				plan.chars[2]  = b64_char({hi[3:0], ka[1:0]});
			end
			PHASE_MID: begin
				plan.first_off = 3'd2;
				plan.last_cnt  = 2'd3;
				plan.chars[0]  = b64_char({ka[5:2], lo[7:6]});
				plan.chars[1]  = b64_char(lo[5:0]);
				plan.chars[2]  = b64_char(hi[7:2]);
				plan.chars[3]  = b64_char({hi[1:0], kb[3:0]});
			end
			default: begin
				plan.first_off = 3'd5;
				plan.last_cnt  = 2'd2;
				plan.chars[0]  = b64_char({kb[5:4], lo[7:4]});
				plan.chars[1]  = b64_char({lo[3:0], hi[7:6]});
				plan.chars[2]  = b64_char(hi[5:0]);
			end
		endcase
	end

endmodule

[rtl/base64_framebuffer_pixel_write.sv]
// ----------------------------------------------------------------------------
// base64_framebuffer_pixel_write
// Pixel writer into a character store holding a base64-encoded RGB565 bitmap.
// ----------------------------------------------------------------------------
//
//  channel   signals                                        direction
//  --------  ---------------------------------------------  ---------
//  in        in_valid/in_ready, kind, pos_x, pos_y,
//            pixel_color, char_address, char_value          to block
//  out       out_valid/out_ready, read_char, dropped        from block
//  cfg       cfg_we, cfg_index, cfg_data                    to block
//
// The block takes one item at a time and is ready again once the result is
// registered. A draw inside the store goes, from acceptance to result,
// through two passes of the shared multiplier (row offset, then division by
// three), a split into group and phase, one read of the single-port
// character store (two for the middle pixel) and three writes to it (four
// for the middle pixel). Raw writes, unused kinds and draws outside the
// image go from decode straight to the result, reads wait for the store's
// read data, and draws beyond the store end after the split. After reset the
// block clears all 11000 characters to 'A', one per cycle, and takes no item
// meanwhile. A stalled result waits in the output register, and the block
// holds its next result until that one is taken.
// ----------------------------------------------------------------------------
module base64_framebuffer_pixel_write
	import b64fb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	input  logic [15:0]       pixel_color,
	input  logic [ADDR_W-1:0] char_address,
	input  logic [7:0]        char_value,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        read_char,
	output logic              dropped,

	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data
);

	// Control state.
	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   clr_q;
	logic [1:0]          cnt_q;
	logic                out_valid_q;

	// Configuration.
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;

	// Latched item.
	logic [1:0]          kind_q;
	logic [POS_W-1:0]    x_q;
	logic [POS_W-1:0]    y_q;
	logic [15:0]         color_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [7:0]          value_q;

	// Working registers of a draw.
	logic [MUL_W-1:0]    mul_q;
	logic [PIX_W-1:0]    pix_q;
	logic [ADDR_W-1:0]   base_q;
	logic [1:0]          phase_q;
	logic [7:0]          keep_a_q;

	// Result being built and the output register.
	logic [7:0]          res_char_q;
	logic                res_drop_q;
	logic [7:0]          read_char_q;
	logic                dropped_q;

	// The shared multiplier.
	logic [PIX_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_W-1:0]    mul_p;

	// Character store port.
	logic [7:0]          mem [STORE_CHARS];
	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_addr;
	logic [7:0]          mem_wdata;
	logic [7:0]          rd_q;

	logic                accept;
	logic                out_free;
	logic [PIX_W-1:0]    pix_d;
	logic [GROUP_W-1:0]  group;
	logic [PIX_W-1:0]    group_x3;
	logic [PIX_W-1:0]    rem_full;
	logic                in_image;
	logic                addr_ok;
	logic [7:0]          keep_a;
	draw_plan_t          plan;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign read_char = read_char_q;
	assign dropped   = dropped_q;

	// The pixel index is the row product plus the column.
	assign pix_d    = mul_q[PIX_W-1:0] + {{(PIX_W-POS_W){1'b0}}, x_q};
	// After the second multiplier pass, mul_q holds pix * 2731, close to pix * 8192 / 3.
	assign group    = mul_q[RECIP_SHIFT +: GROUP_W];
	assign group_x3 = {1'b0, group} + {group, 1'b0};
	assign rem_full = pix_q - group_x3;

	assign in_image = ({1'b0, x_q} < width_q) && ({1'b0, y_q} < height_q);
	assign addr_ok  = (addr_q < ADDR_W'(STORE_CHARS));

	// For the middle pixel the character at offset 2 was read first and kept.
	assign keep_a = (phase_q == PHASE_MID) ? keep_a_q : rd_q;

	assign mul_p = mul_a * mul_b;

	b64fb_codec u_codec (
		.phase  (phase_q),
		.color  (color_q),
		.keep_a (keep_a),
		.keep_b (rd_q),
		.plan   (plan)
	);

	// Sequencer: next state, multiplier operands and memory port.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = clr_q;
		mem_wdata = CHAR_FILL;
		mul_a     = {{(PIX_W-POS_W){1'b0}}, y_q};
		mul_b     = {{(MUL_B_W-DIM_W){1'b0}}, width_q};
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == ADDR_W'(STORE_CHARS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				// The multiplier forms the row offset y * width here for draws.
				mem_addr  = addr_q;
				mem_wdata = value_q;
				case (kind_q)
					KIND_DRAW: begin
						state_d = in_image ? ST_MUL_DIV : ST_FINISH;
					end
					KIND_WRITE: begin
						mem_we  = addr_ok;
						state_d = ST_FINISH;
					end
					KIND_READ: begin
						mem_re  = addr_ok;
						state_d = addr_ok ? ST_RD_WAIT : ST_FINISH;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_MUL_DIV: begin
				mul_a   = pix_d;
				mul_b   = RECIP_3;
				state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				state_d = (group < GROUP_W'(PIX_GROUPS)) ? ST_RD_A : ST_FINISH;
			end
			ST_RD_A: begin
				mem_re   = 1'b1;
				mem_addr = base_q + ((phase_q == PHASE_LAST) ? ADDR_W'(5) : ADDR_W'(2));
				state_d  = (phase_q == PHASE_MID) ? ST_RD_B : ST_WRITE;
			end
			ST_RD_B: begin
				mem_re   = 1'b1;
				mem_addr = base_q + ADDR_W'(5);
				state_d  = ST_WRITE;
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = base_q + {{(ADDR_W-3){1'b0}}, plan.first_off}
				            + {{(ADDR_W-2){1'b0}}, cnt_q};
				mem_wdata = plan.chars[cnt_q];
				if (cnt_q == plan.last_cnt) begin
					state_d = ST_FINISH;
				end
			end
			ST_RD_WAIT: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Clear counter walks the store once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// Write counter for the three or four characters of a draw.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_WRITE) begin
			cnt_q <= cnt_q + 2'd1;
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	// Item and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			x_q     <= pos_x;
			y_q     <= pos_y;
			color_q <= pixel_color;
			addr_q  <= char_address;
			value_q <= char_value;
		end
		if (state_q == ST_DECODE || state_q == ST_MUL_DIV) begin
			mul_q <= mul_p;
		end
		if (state_q == ST_MUL_DIV) begin
			pix_q <= pix_d;
		end
		if (state_q == ST_SPLIT) begin
			base_q  <= ADDR_W'(HEADER_CHARS) + ADDR_W'({group, 3'b000});
			phase_q <= rem_full[1:0];
		end
		if (state_q == ST_RD_B) begin
			keep_a_q <= rd_q;
		end
	end

	// Result fields: set while the item is worked on, moved out in ST_FINISH.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DECODE: begin
				res_char_q <= '0;
				case (kind_q)
					KIND_DRAW:  res_drop_q <= !in_image;
					KIND_WRITE: res_drop_q <= !addr_ok;
					KIND_READ:  res_drop_q <= !addr_ok;
					default:    res_drop_q <= 1'b0;
				endcase
			end
			ST_SPLIT: begin
				res_drop_q <= (group >= GROUP_W'(PIX_GROUPS));
			end
			ST_RD_WAIT: begin
				res_char_q <= rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			read_char_q <= res_char_q;
			dropped_q   <= res_drop_q;
		end
	end

	// Single-port character store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

endmodule

[tb/sv/pixel_store_checker.sv]
// ----------------------------------------------------------------------------
// pixel_store_checker
// Watches the request, reply and configuration ports of the framebuffer pixel
// writer, keeps a mirror of the encoded character store and compares every
// reply against the predicted one.
// ----------------------------------------------------------------------------
module pixel_store_checker
	import b64fb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	input  logic [15:0]       pixel_color,
	input  logic [ADDR_W-1:0] char_address,
	input  logic [7:0]        char_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        read_char,
	input  logic              dropped,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	output int                mismatch_count,
	output int                replies_due
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       drop;
	} reply_t;

	reply_t           expected_replies[$];
	logic [7:0]       char_mirror [0:STORE_CHARS-1];
	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;
	int               replies_seen;

	// Six-bit value to its base64 character.
	function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
		if (s <= 6'd25) begin
			return 8'd65 + {2'b00, s};
		end else if (s <= 6'd51) begin
			return 8'd97 + ({2'b00, s} - 8'd26);
		end else if (s <= 6'd61) begin
			return 8'd48 + ({2'b00, s} - 8'd52);
		end else if (s == 6'd62) begin
			return 8'd43;
		end
		return 8'd47;
	endfunction

	// Character back to its value; the pad character decodes to 64 and
	// anything outside the alphabet to 255.
	function automatic logic [7:0] char_to_sextet(input logic [7:0] c);
		if (c inside {[8'd65:8'd90]})  return c - 8'd65;
		if (c inside {[8'd97:8'd122]}) return c - 8'd71;
		if (c inside {[8'd48:8'd57]})  return c + 8'd4;
		if (c == 8'd43)                return 8'd62;
		if (c == 8'd47)                return 8'd63;
		if (c == 8'd61)                return 8'd64;
		return 8'd255;
	endfunction

	// Re-encodes the characters touched by one pixel; returns 1 when dropped.
	function automatic logic paint_mirror(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [15:0] color);
		int         pix;
		int         base;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] keep;
		lo = color[7:0];
		hi = color[15:8];
		if (x >= cur_width || y >= cur_height) return 1'b1;
		pix = int'(y) * int'(cur_width) + int'(x);
		if (pix / 3 >= PIX_GROUPS) return 1'b1;
		base = HEADER_CHARS + (pix / 3) * 8;
		case (pix % 3)
			0: begin
				keep = char_to_sextet(char_mirror[base + 2]);
				char_mirror[base]     = sextet_to_char(lo[7:2]);
				char_mirror[base + 1] = sextet_to_char({lo[1:0], hi[7:4]});
				char_mirror[base + 2] = sextet_to_char({hi[3:0], keep[1:0]});
			end
			1: begin
				keep = char_to_sextet(char_mirror[base + 2]);
				char_mirror[base + 2] = sextet_to_char({keep[5:2], lo[7:6]});
				char_mirror[base + 3] = sextet_to_char(lo[5:0]);
				char_mirror[base + 4] = sextet_to_char(hi[7:2]);
				keep = char_to_sextet(char_mirror[base + 5]);
				char_mirror[base + 5] = sextet_to_char({hi[1:0], keep[3:0]});
			end
			default: begin
				keep = char_to_sextet(char_mirror[base + 5]);
				char_mirror[base + 5] = sextet_to_char({keep[5:4], lo[7:4]});
				char_mirror[base + 6] = sextet_to_char({lo[3:0], hi[7:6]});
				char_mirror[base + 7] = sextet_to_char(hi[5:0]);
			end
		endcase
		return 1'b0;
	endfunction

	function automatic reply_t serve_request(input logic [1:0] k, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [15:0] color, input logic [ADDR_W-1:0] addr,
			input logic [7:0] value);
		reply_t r;
		r = '0;
		case (k)
			KIND_DRAW: r.drop = paint_mirror(x, y, color);
			KIND_WRITE: begin
				if (addr < STORE_CHARS) char_mirror[addr] = value;
				else r.drop = 1'b1;
			end
			KIND_READ: begin
				if (addr < STORE_CHARS) r.ch = char_mirror[addr];
				else r.drop = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int want, input int got);
		$display("[%0t] reply %0d: %s expected 0x%0h, got 0x%0h", $realtime, replies_seen,
			field, want, got);
		mismatch_count = mismatch_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < STORE_CHARS; i++) char_mirror[i] = CHAR_FILL;
			cur_width = DIM_W'(MAX_WIDTH);
			cur_height = DIM_W'(MAX_HEIGHT);
			expected_replies.delete();
			replies_seen = 0;
			mismatch_count = 0;
			replies_due <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WIDTH) cur_width = cfg_data;
				else cur_height = cfg_data;
			end
			// The reply leaving at this edge always belongs to an earlier item.
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("reply with no request pending, read_char", 0, read_char);
				end else begin
					want = expected_replies.pop_front();
					if (read_char !== want.ch) report_mismatch("read_char", want.ch, read_char);
					if (dropped !== want.drop) report_mismatch("dropped", want.drop, dropped);
				end
				replies_seen = replies_seen + 1;
			end
			if (in_valid && in_ready) begin
				expected_replies.push_back(serve_request(kind, pos_x, pos_y, pixel_color,
					char_address, char_value));
			end
			replies_due <= expected_replies.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the base64 framebuffer pixel writer: a directed
// opening, then phases of random requests under several image sizes, most with
// random gaps on both channels, checked by pixel_store_checker.
// ----------------------------------------------------------------------------
module tb
	import b64fb_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// Kind value that the block ignores.
	localparam logic [1:0] KIND_NONE = 2'd3;

	// Nothing is accepted during the clearing pass after reset, which writes all
	// 11000 characters.
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 50;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        kind;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [15:0]       pixel_color;
	logic [ADDR_W-1:0] char_address;
	logic [7:0]        char_value;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        read_char;
	logic              dropped;
	logic              cfg_we;
	logic              cfg_index;
	logic [DIM_W-1:0]  cfg_data;

	int mismatch_count;
	int replies_due;
	int idle_cycles = 0;

	// When set, neither side inserts gaps, so back-to-back traffic is seen too.
	bit no_gaps;

	// Start of the group most recently drawn to; reads and raw writes aim near
	// it so that freshly encoded characters get checked and neighbors decoded.
	int hot_addr;

	// Image sizes per phase: the nominal size, one pixel, the register maximum
	// (well past the store, so the store bound drops draws), zero sizes, thin
	// strips and an odd size; the last two phases pick sizes at random.
	int phase_w [PHASES] = '{64, 1, 127, 0, 0, 64, 127, 3, 64, 37, 0, 0};
	int phase_h [PHASES] = '{64, 1, 127, 0, 64, 0, 1, 64, 1, 50, 0, 0};

	base64_framebuffer_pixel_write uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pixel_color  (pixel_color),
		.char_address (char_address),
		.char_value   (char_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_char    (read_char),
		.dropped      (dropped),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pixel_store_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pixel_color    (pixel_color),
		.char_address   (char_address),
		.char_value     (char_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_char      (read_char),
		.dropped        (dropped),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.replies_due    (replies_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Draws how many cycles a side waits before its next item.
	function automatic int pick_gap();
		if (no_gaps) return 0;
		return $urandom_range(0, 6);
	endfunction

	// Offers one item and returns at the edge where it is accepted. The task
	// is always entered right after a rising edge. With a zero gap valid just
	// stays high, so it is never lowered and raised in the same time step.
	task automatic send_request(input logic [1:0] k, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [15:0] color, input logic [ADDR_W-1:0] addr,
			input logic [7:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		pos_x <= x;
		pos_y <= y;
		pixel_color <= color;
		char_address <= addr;
		char_value <= value;
		// in_ready read right after the edge still holds its pre-edge value.
		do @(posedge clk); while (!in_ready);
	endtask

	// Both registers go in on consecutive edges with the enable held high.
	task automatic set_image_size(input int w, input int h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= DIM_W'(w);
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= DIM_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every reply has come back, then lets the block settle. The
	// first edge lets the count take in an item accepted at the current edge.
	task automatic wait_drained(input int settle);
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// One random request shaped for the current image size. Most draws land
	// inside the image, and most reads and raw writes hit the group that was
	// last drawn, with pad and non-alphabet characters mixed into raw writes.
	task automatic random_request(input int w, input int h);
		int            roll;
		logic [1:0]    k;
		logic [5:0]    x;
		logic [5:0]    y;
		logic [15:0]   c;
		logic [13:0]   a;
		logic [7:0]    v;
		roll = $urandom_range(0, 99);
		x = 6'($urandom);
		y = 6'($urandom);
		c = 16'($urandom);
		a = 14'($urandom);
		v = 8'($urandom);
		if (roll < 55) begin
			k = KIND_DRAW;
			if ($urandom_range(0, 9) < 8) begin
				if (w > 0) x = 6'($urandom_range(0, (w > 64 ? 64 : w) - 1));
				if (h > 0) y = 6'($urandom_range(0, (h > 64 ? 64 : h) - 1));
			end
			hot_addr = HEADER_CHARS + ((int'(y) * w + int'(x)) / 3) * 8;
			if (hot_addr > STORE_CHARS - 8) hot_addr = HEADER_CHARS;
		end else if (roll < 70) begin
			k = KIND_WRITE;
			if ($urandom_range(0, 3) != 0) a = ADDR_W'(hot_addr + $urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: v = 8'd61;
				1: v = 8'd65 + 8'($urandom_range(0, 25));
				default: ;
			endcase
		end else if (roll < 95) begin
			k = KIND_READ;
			if ($urandom_range(0, 4) != 0) a = ADDR_W'(hot_addr + $urandom_range(0, 7));
		end else begin
			k = KIND_NONE;
		end
		send_request(k, x, y, c, a, v);
	endtask

	// The reply side: a random stall before each item, then ready stays high
	// until a reply is taken.
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int w;
		int h;
		no_gaps = 1'b0;
		hot_addr = HEADER_CHARS;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_DRAW;
		pos_x <= '0;
		pos_y <= '0;
		pixel_color <= '0;
		char_address <= '0;
		char_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_WIDTH;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block clears its store first; the size registers can be written
		// meanwhile since no item is in flight.
		set_image_size(MAX_WIDTH, MAX_HEIGHT);

		// Directed opening on the full 64 x 64 image. The first group gets all
		// three phases, then its shared characters are overwritten with the pad
		// character and with non-alphabet bytes before the neighbors are redrawn.
		send_request(KIND_DRAW, 6'd0, 6'd0, 16'hFFFF, '0, '0);
		send_request(KIND_DRAW, 6'd1, 6'd0, 16'h0000, '0, '0);
		send_request(KIND_DRAW, 6'd2, 6'd0, 16'hA5C3, '0, '0);
		send_request(KIND_READ, '0, '0, '0, 14'd72, '0);
		send_request(KIND_READ, '0, '0, '0, 14'd74, '0);
		send_request(KIND_READ, '0, '0, '0, 14'd77, '0);
		send_request(KIND_WRITE, '0, '0, '0, 14'd74, 8'd61);
		send_request(KIND_DRAW, 6'd1, 6'd0, 16'h1234, '0, '0);
		send_request(KIND_WRITE, '0, '0, '0, 14'd77, 8'hFF);
		send_request(KIND_DRAW, 6'd2, 6'd0, 16'hFFFF, '0, '0);
		send_request(KIND_WRITE, '0, '0, '0, 14'd74, 8'h00);
		send_request(KIND_DRAW, 6'd0, 6'd0, 16'h8001, '0, '0);
		send_request(KIND_READ, '0, '0, '0, 14'd74, '0);
		send_request(KIND_READ, '0, '0, '0, 14'd77, '0);
		// Last pixel of the image sits in the last group of the store.
		send_request(KIND_DRAW, 6'd63, 6'd63, 16'hFFFF, '0, '0);
		send_request(KIND_READ, '0, '0, '0, 14'd10999, '0);
		send_request(KIND_READ, '0, '0, '0, 14'd10997, '0);
		// Addresses past the end of the store are refused.
		send_request(KIND_READ, '0, '0, '0, 14'd11000, '0);
		send_request(KIND_WRITE, '0, '0, '0, 14'h3FFF, 8'hAA);
		send_request(KIND_READ, '0, '0, '0, 14'h3FFF, '0);
		// The unused kind and a header character round trip.
		send_request(KIND_NONE, 6'h3F, 6'h3F, 16'hFFFF, 14'h3FFF, 8'hFF);
		send_request(KIND_WRITE, '0, '0, '0, 14'd0, 8'h42);
		send_request(KIND_READ, '0, '0, '0, 14'd0, '0);

		// Random phases, each under its own image size, reconfigured only once
		// every reply of the previous phase is back. Valid drops at the edge
		// that took the last item, so that item is not offered again. Every
		// third phase runs with no gaps on either side.
		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			wait_drained(4);
			w = phase_w[p];
			h = phase_h[p];
			if (p >= PHASES - 2) begin
				w = $urandom_range(1, 127);
				h = $urandom_range(1, 127);
			end
			set_image_size(w, h);
			no_gaps = (p % 3 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) random_request(w, h);
		end
		in_valid <= 1'b0;
		no_gaps = 1'b0;

		// Drain, give the block a little time for anything unexpected, then
		// give the verdict.
		wait_drained(20);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
